[src/u2i_pkg.sv]
// Package: shared types, constants and register codes for the UYVY to I420 converter.
package u2i_pkg;

    // Design parameter defaults
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int LUMA_OFF_W = 22;
    localparam int CHR_OFF_W  = 20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // One packed macropixel
    typedef struct packed {
        logic [PIX_W-1:0] cb_byte;
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] cr_byte;
        logic [PIX_W-1:0] luma_second;
    } t_pix;

    // One planar result
    typedef struct packed {
        logic [PIX_W-1:0]      luma_out_a;
        logic [PIX_W-1:0]      luma_out_b;
        logic [LUMA_OFF_W-1:0] luma_offset;
        logic                  chroma_valid;
        logic [PIX_W-1:0]      cb_out;
        logic [PIX_W-1:0]      cr_out;
        logic [CHR_OFF_W-1:0]  chroma_offset;
        logic                  frame_end;
    } t_res;

    // Register write
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
    } t_cfg;

endpackage

[src/u2i_stream_if.sv]
// Interface: valid/ready channel carrying one payload of a given type.
interface u2i_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/u2i_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module u2i_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, read port holds its data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[src/uyvy_to_i420_converter.sv]
// Top level: packed UYVY 4:2:2 macropixel stream to planar I420 results.
// Throughput: one macropixel per cycle unless the output stalls; the chroma line RAM has
// separate read and write ports. An input transfer passes the RAM read stage, then the output
// register, before its result is valid; an output stall can hold it in either register.
// Reset: synchronous active-low; counters and offsets clear, width 640, height 480.
// The chroma line RAM is not cleared; an even row fills each entry before the odd row reads it.
module uyvy_to_i420_converter #(
    parameter int MAX_WIDTH  = u2i_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = u2i_pkg::MAX_HEIGHT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    u2i_stream_if.sink   i_pix,
    u2i_stream_if.sink   i_cfg,
    u2i_stream_if.source o_res
);
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW    = (($clog2(MAXD + 1) > u2i_pkg::CFG_W) ?
                            $clog2(MAXD + 1) : u2i_pkg::CFG_W) + 1;
    localparam int PW    = u2i_pkg::PIX_W;
    localparam logic [DW-1:0] MAXW_EVEN = DW'(MAX_WIDTH - (MAX_WIDTH % 2));
    localparam logic [DW-1:0] MAXH      = DW'(MAX_HEIGHT);

    // Registers
    logic [u2i_pkg::CFG_W-1:0] r_frame_width;
    logic [u2i_pkg::CFG_W-1:0] r_frame_height;

    // Counters
    logic [CW-1:0]                  r_col;
    logic [RW-1:0]                  r_row;
    logic [u2i_pkg::LUMA_OFF_W-1:0] r_luma_pos;
    logic [u2i_pkg::CHR_OFF_W-1:0]  r_chroma_pos;

    // Read stage
    logic                           r_b_valid;
    u2i_pkg::t_pix                  r_b_pix;
    logic                           r_b_odd;
    logic                           r_b_last_row;
    logic                           r_b_frame_end;
    logic [u2i_pkg::LUMA_OFF_W-1:0] r_b_luma_off;
    logic [u2i_pkg::CHR_OFF_W-1:0]  r_b_chroma_off;

    // Output register
    logic          r_o_valid;
    u2i_pkg::t_res r_o_res;
    u2i_pkg::t_res n_o_res;

    logic          o_load_ok;
    logic          b_adv;
    logic          in_xfer;
    logic [DW-1:0] w_even;
    logic [DW-1:0] eff_w;
    logic [DW-1:0] macros;
    logic [DW-1:0] eff_h;
    logic          last_col;
    logic          last_row;
    logic          odd_row;
    logic          chroma_now;
    logic [2*PW-1:0] rd_data;
    logic [PW:0]   cb_sum;
    logic [PW:0]   cr_sum;

    // Handshakes
    assign o_load_ok   = !r_o_valid || o_res.ready;
    assign b_adv       = !r_b_valid || o_load_ok;
    assign i_pix.ready = b_adv;
    assign in_xfer     = i_pix.valid && b_adv;
    assign i_cfg.ready = 1'b1;

    // Effective frame size
    always_comb begin
        w_even = DW'({r_frame_width[u2i_pkg::CFG_W-1:1], 1'b0});
        eff_w  = w_even;
        if (eff_w < DW'(2)) begin
            eff_w = DW'(2);
        end
        if (eff_w > MAXW_EVEN) begin
            eff_w = MAXW_EVEN;
        end
        macros = eff_w >> 1;
        eff_h  = DW'(r_frame_height);
        if (eff_h < DW'(1)) begin
            eff_h = DW'(1);
        end
        if (eff_h > MAXH) begin
            eff_h = MAXH;
        end
    end

    assign last_col   = (DW'(r_col) + DW'(1)) >= macros;
    assign last_row   = (DW'(r_row) + DW'(1)) >= eff_h;
    assign odd_row    = r_row[0];
    assign chroma_now = odd_row || last_row;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= u2i_pkg::FRAME_WIDTH_RST;
            r_frame_height <= u2i_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                u2i_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data.value;
                u2i_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // Raster counters and plane offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_luma_pos   <= '0;
            r_chroma_pos <= '0;
        end else if (in_xfer) begin
            if (last_col && last_row) begin
                r_col        <= '0;
                r_row        <= '0;
                r_luma_pos   <= '0;
                r_chroma_pos <= '0;
            end else begin
                r_luma_pos <= r_luma_pos + u2i_pkg::LUMA_OFF_W'(2);
                if (chroma_now) begin
                    r_chroma_pos <= r_chroma_pos + u2i_pkg::CHR_OFF_W'(1);
                end
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Chroma line RAM: even rows write, odd rows read
    u2i_ram #(
        .WIDTH (2 * PW),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && !odd_row),
        .i_wr_addr (r_col),
        .i_wr_data ({i_pix.data.cb_byte, i_pix.data.cr_byte}),
        .i_rd_en   (in_xfer && odd_row),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_adv) begin
            r_b_valid <= i_pix.valid;
        end
    end

    // Read stage payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_b_pix        <= i_pix.data;
            r_b_odd        <= odd_row;
            r_b_last_row   <= last_row;
            r_b_frame_end  <= last_col && last_row;
            r_b_luma_off   <= r_luma_pos;
            r_b_chroma_off <= r_chroma_pos;
        end
    end

    // Chroma average and result assembly
    assign cb_sum = {1'b0, rd_data[2*PW-1:PW]} + {1'b0, r_b_pix.cb_byte};
    assign cr_sum = {1'b0, rd_data[PW-1:0]} + {1'b0, r_b_pix.cr_byte};

    always_comb begin
        n_o_res               = '0;
        n_o_res.luma_out_a    = r_b_pix.luma_first;
        n_o_res.luma_out_b    = r_b_pix.luma_second;
        n_o_res.luma_offset   = r_b_luma_off;
        n_o_res.frame_end     = r_b_frame_end;
        n_o_res.chroma_valid  = r_b_odd || r_b_last_row;
        if (r_b_odd) begin
            n_o_res.cb_out = cb_sum[PW:1];
            n_o_res.cr_out = cr_sum[PW:1];
        end else if (r_b_last_row) begin
            n_o_res.cb_out = r_b_pix.cb_byte;
            n_o_res.cr_out = r_b_pix.cr_byte;
        end
        if (r_b_odd || r_b_last_row) begin
            n_o_res.chroma_offset = r_b_chroma_off;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load_ok) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ok && r_b_valid) begin
            r_o_res <= n_o_res;
        end
    end

    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_o_res;
endmodule
